/* hw/rtl/tsrc_pkg.sv */
// Shared constants and types for the two-square representation counter.
// No dependencies; compiled first.
`default_nettype none
package tsrc_pkg;

  localparam int FIELD_WIDTH       = 16;
  localparam int COUNT_WIDTH       = 16;
  localparam int OPERAND_WIDTH_DEF = 16;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef struct packed {
    logic busy;
    logic done;
  } isq_sts_t;

endpackage
`default_nettype wire

/* hw/rtl/tsrc_in_if.sv */
// Input channel: valid/ready with the two operands.
// Depends on tsrc_pkg.
`default_nettype none
interface tsrc_in_if;
  logic                             valid;
  logic                             ready;
  logic [tsrc_pkg::FIELD_WIDTH-1:0] first_value;
  logic [tsrc_pkg::FIELD_WIDTH-1:0] second_value;

  modport source (output valid, output first_value, output second_value, input ready);
  modport sink   (input valid, input first_value, input second_value, output ready);
endinterface
`default_nettype wire

/* hw/rtl/tsrc_out_if.sv */
// Result channel: valid/ready with the pair count.
// Depends on tsrc_pkg.
`default_nettype none
interface tsrc_out_if;
  logic                             valid;
  logic                             ready;
  logic [tsrc_pkg::COUNT_WIDTH-1:0] pair_count;

  modport source (output valid, output pair_count, input ready);
  modport sink   (input valid, input pair_count, output ready);
endinterface
`default_nettype wire

/* hw/rtl/tsrc_isqrt.sv */
// Iterative integer square root, one result bit per cycle (digit by digit).
// Gives root and remainder. Depends on tsrc_pkg.
`default_nettype none
module tsrc_isqrt #(
  parameter int WIDTH = 33
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [WIDTH-1:0]             value,
  output tsrc_pkg::isq_sts_t                sts,
  output logic [(WIDTH+(WIDTH%2))/2-1:0]    root,
  output logic [WIDTH-1:0]                  rem
);
  import tsrc_pkg::*;

  localparam int NW    = WIDTH + (WIDTH % 2);
  localparam int STEPS = NW / 2;
  localparam int CW    = $clog2(STEPS + 1);

  logic [NW-1:0] n_r, res_r, bit_r;
  logic [NW-1:0] n_nxt, res_nxt, bit_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [NW-1:0] sum;

  assign sum = res_r + bit_r;

  always_comb begin
    n_nxt    = n_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      n_nxt    = NW'(value);
      res_nxt  = '0;
      bit_nxt  = NW'(1) << (NW - 2);
      cnt_nxt  = CW'(STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (n_r >= sum) begin
        n_nxt   = n_r - sum;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    n_r   <= n_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign root     = res_r[STEPS-1:0];
  assign rem      = n_r[WIDTH-1:0];

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("isqrt started while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("isqrt did not go busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r) else $error("isqrt done without a run");

endmodule
`default_nettype wire

/* hw/rtl/two_square_representation_counter.sv */
// Two-square representation counter, top level.
// Depends on tsrc_pkg, tsrc_in_if, tsrc_out_if and tsrc_isqrt.
//
// Forms T = A*A + B*B and counts pairs 1 <= x < y with x*x + y*y = T, x*x < T/2,
// returning one saturating 16-bit count per operand pair. One item is in work
// at a time; in_ch.ready is high only while idle. From one input transfer to
// the next an item passes through the idle state, the shared multiplier for T
// (A*A, then B*B added), a state to start the square-root unit, the run in it
// for y0 = isqrt(T) over EW+1 root bits, EW being the effective operand width
// (16 by default), collection of the root, then a scan in which every step
// either advances x (x*x and T - x*x kept by add and subtract) or steps y down,
// then a step to end the scan and one to post the count. The result sits in an
// output register, so a new pair can be taken while it waits.
`default_nettype none
module two_square_representation_counter #(
  parameter int OPERAND_WIDTH = tsrc_pkg::OPERAND_WIDTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  tsrc_in_if.sink   in_ch,
  tsrc_out_if.source out_ch
);
  import tsrc_pkg::*;

  localparam int EW = (OPERAND_WIDTH < FIELD_WIDTH) ? OPERAND_WIDTH : FIELD_WIDTH;
  localparam int TW = 2 * EW + 1;
  localparam int XW = EW + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQA  = 3'd1;
  localparam logic [2:0] S_SQB  = 3'd2;
  localparam logic [2:0] S_RGO  = 3'd3;
  localparam logic [2:0] S_ROOT = 3'd4;
  localparam logic [2:0] S_SCAN = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]             state_r, state_nxt;
  logic [EW-1:0]          a_r, a_nxt, b_r, b_nxt;
  logic [TW-1:0]          t_r, t_nxt, half_r, half_nxt;
  logic [TW-1:0]          xsq_r, xsq_nxt, rem_r, rem_nxt, ysq_r, ysq_nxt;
  logic [XW-1:0]          x_r, x_nxt, y_r, y_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt, out_cnt_r, out_cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic [EW-1:0]   mul_op;
  logic [2*EW-1:0] prod;
  logic [TW-1:0]   x_inc, y_dec;

  logic            isq_start;
  isq_sts_t        isq_sts;
  logic [XW-1:0]   isq_root;
  logic [TW-1:0]   isq_rem;

  tsrc_isqrt #(.WIDTH(TW)) u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (isq_start),
    .value (t_r),
    .sts   (isq_sts),
    .root  (isq_root),
    .rem   (isq_rem)
  );

  assign mul_op    = (state_r == S_SQA) ? a_r : b_r;
  assign prod      = mul_op * mul_op;
  assign x_inc     = TW'({x_r, 1'b1});
  assign y_dec     = TW'({y_r, 1'b0}) - TW'(1);
  assign isq_start = (state_r == S_RGO);

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.pair_count = out_cnt_r;

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    t_nxt         = t_r;
    half_nxt      = half_r;
    xsq_nxt       = xsq_r;
    rem_nxt       = rem_r;
    ysq_nxt       = ysq_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    cnt_nxt       = cnt_r;
    out_cnt_nxt   = out_cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          a_nxt     = in_ch.first_value[EW-1:0];
          b_nxt     = in_ch.second_value[EW-1:0];
          state_nxt = S_SQA;
        end
      end
      S_SQA: begin
        t_nxt     = TW'(prod);
        state_nxt = S_SQB;
      end
      S_SQB: begin
        t_nxt     = t_r + TW'(prod);
        state_nxt = S_RGO;
      end
      S_RGO: begin
        half_nxt  = t_r >> 1;
        x_nxt     = XW'(1);
        xsq_nxt   = TW'(1);
        rem_nxt   = t_r - TW'(1);
        cnt_nxt   = '0;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        if (isq_sts.done) begin
          y_nxt     = isq_root;
          ysq_nxt   = t_r - isq_rem;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (xsq_r >= half_r) begin
          state_nxt = S_DONE;
        end else if (ysq_r > rem_r) begin
          y_nxt   = y_r - XW'(1);
          ysq_nxt = ysq_r - y_dec;
        end else begin
          if (ysq_r == rem_r && y_r > x_r && cnt_r != COUNT_MAX) begin
            cnt_nxt = cnt_r + COUNT_WIDTH'(1);
          end
          x_nxt   = x_r + XW'(1);
          xsq_nxt = xsq_r + x_inc;
          rem_nxt = rem_r - x_inc;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_cnt_nxt   = cnt_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    t_r       <= t_nxt;
    half_r    <= half_nxt;
    xsq_r     <= xsq_nxt;
    rem_r     <= rem_nxt;
    ysq_r     <= ysq_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    cnt_r     <= cnt_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  a_root_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROOT) |-> (isq_sts.busy || isq_sts.done))
    else $error("waiting on idle square-root unit");
  a_rem_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (rem_r + xsq_r == t_r))
    else $error("remainder lost track of x squared");
  a_cnt_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |=> (cnt_r >= $past(cnt_r)))
    else $error("pair count decreased during scan");
  a_out_not_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_cnt_r)))
    else $error("pending result overwritten");

endmodule
`default_nettype wire
